FILE: sv/pbp_pkg.sv
// ----------------------------------------------------------------------------
// pbp_pkg: shared types and constants for the perpendicular baseline pixel
// Register indexes, widths and the stage payload types of the pipeline.
// ----------------------------------------------------------------------------
package pbp_pkg;

    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_NEAR_RANGE     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_RANGE_STEP     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_EARTH_RADIUS   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_HEIGHT_START   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HEIGHT_STEP    = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_BASELINE_START = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_BASELINE_STEP  = 3'd6;

    localparam logic [31:0] EARTH_RADIUS_RST = 32'd1630976000;

    // quotient bits of eta, one per divider stage
    localparam int QBits = 25;
    // square root result bits, one per root stage
    localparam int SBits = 25;
    // remainder / divisor width of the divider (D < 2^68)
    localparam int DivW = 70;

    // classification of one pixel before the divide
    typedef struct packed {
        logic err;      // no valid look angle
        logic clamp;    // eta clamped to minus one
        logic neg;      // sign of eta
    } geo_flags_t;

endpackage

FILE: sv/pbp_div_stage.sv
// ----------------------------------------------------------------------------
// pbp_div_stage: one restoring step of the eta divider
// Shifts the remainder left, subtracts the divisor when it fits, and appends
// one quotient bit.
// ----------------------------------------------------------------------------
module pbp_div_stage
    import pbp_pkg::*;
(
    input  logic [DivW-1:0]  rem_in,
    input  logic [DivW-1:0]  div_in,
    input  logic [QBits-1:0] q_in,
    output logic [DivW-1:0]  rem_out,
    output logic [QBits-1:0] q_out
);

    logic [DivW:0] shifted;
    logic          fits;

    // trial subtract
    assign shifted = {rem_in, 1'b0};
    assign fits    = shifted >= {1'b0, div_in};
    assign rem_out = fits ? DivW'(shifted - {1'b0, div_in}) : shifted[DivW-1:0];
    assign q_out   = {q_in[QBits-2:0], fits};

endmodule

FILE: sv/perpendicular_baseline_pixel.sv
// ----------------------------------------------------------------------------
// perpendicular_baseline_pixel: perpendicular baseline of one grid pixel
// Fixed point pipeline: interpolation, law of cosines, bit-serial divide,
// bit-serial square root, final dot product and saturation.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  pixel    | in        | start, busy             | row, col
//  result   | out       | done (one-cycle strobe) | bperp, geometry_error
//  config   | in        | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
//  One pixel per cycle; each pixel passes through the front 5 stages, 25
//  divide stages, 1 radicand stage, 25 root stages and 4 back stages; the
//  divider and square root chains produce one bit per stage.
//  busy stays low: the receiver cannot stall, so the pipeline never holds.
//  Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module perpendicular_baseline_pixel #(
    parameter int MAX_ROWS = 16384,
    parameter int MAX_COLS = 16384
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [13:0]                 row,
    input  logic [13:0]                 col,
    output logic                        done,
    output logic signed [31:0]          bperp,
    output logic                        geometry_error,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pbp_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [63:0]                 cfg_data
);
    import pbp_pkg::*;

    localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // ---------------- configuration registers
    logic [31:0] near_range_reg, range_step_reg, earth_radius_reg;
    logic [31:0] height_start_reg, height_step_reg;
    logic [63:0] baseline_start_reg, baseline_step_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_range_reg     <= '0;
            range_step_reg     <= '0;
            earth_radius_reg   <= EARTH_RADIUS_RST;
            height_start_reg   <= '0;
            height_step_reg    <= '0;
            baseline_start_reg <= '0;
            baseline_step_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NEAR_RANGE:     near_range_reg     <= cfg_data[31:0];
                REG_RANGE_STEP:     range_step_reg     <= cfg_data[31:0];
                REG_EARTH_RADIUS:   earth_radius_reg   <= cfg_data[31:0];
                REG_HEIGHT_START:   height_start_reg   <= cfg_data[31:0];
                REG_HEIGHT_STEP:    height_step_reg    <= cfg_data[31:0];
                REG_BASELINE_START: baseline_start_reg <= cfg_data;
                REG_BASELINE_STEP:  baseline_step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: index reduction
    logic        v1_reg;
    logic [15:0] r1_reg, k1_reg;
    logic [15:0] r_in, k_in;

    always_comb
    begin
        r_in = 16'(row % MAX_ROWS);
        k_in = 16'(col % MAX_COLS);
        if (RowW < 16) r_in = 16'(r_in[RowW-1:0]);
        if (ColW < 16) k_in = 16'(k_in[ColW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else        v1_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        r1_reg <= r_in;
        k1_reg <= k_in;
    end

    // stage 2: interpolation products (three 32x17 multiplies and one 32x16)
    logic               v2_reg;
    logic signed [48:0] bh_p_reg, bv_p_reg, h_p_reg;
    logic        [47:0] rho_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else        v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        bh_p_reg  <= $signed(baseline_step_reg[63:32]) * $signed({1'b0, r1_reg});
        bv_p_reg  <= $signed(baseline_step_reg[31:0]) * $signed({1'b0, r1_reg});
        h_p_reg   <= $signed(height_step_reg) * $signed({1'b0, r1_reg});
        rho_p_reg <= range_step_reg * k1_reg;
    end

    // stage 3: bh, bv, rho, c
    logic               v3_reg;
    logic signed [41:0] bh3_reg, bv3_reg;
    logic        [32:0] rho3_reg;
    logic signed [34:0] c3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else        v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        bh3_reg  <= 42'(signed'(baseline_start_reg[63:32])) + 42'(bh_p_reg >>> 8);
        bv3_reg  <= 42'(signed'(baseline_start_reg[31:0])) + 42'(bv_p_reg >>> 8);
        rho3_reg <= 33'(near_range_reg) + 33'(rho_p_reg[47:16]);
        c3_reg   <= 35'(earth_radius_reg) + 35'(height_start_reg)
                  + 35'(h_p_reg >>> 16);
    end

    // stage 4: classification and squares
    logic               v4_reg;
    logic signed [41:0] bh4_reg, bv4_reg;
    logic [32:0]        rho4_reg;
    logic [33:0]        c4_reg;
    geo_flags_t         f4_reg;
    logic [67:0]        rho2_reg, c2_reg;
    logic [63:0]        re2_reg;
    logic [33:0]        uc, diff;
    logic               degen;

    always_comb
    begin
        degen = (rho3_reg == '0) || (c3_reg <= 0);
        uc    = c3_reg[33:0];
        diff  = (uc > 34'(rho3_reg)) ? uc - 34'(rho3_reg) : 34'(rho3_reg) - uc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else        v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        bh4_reg      <= bh3_reg;
        bv4_reg      <= bv3_reg;
        rho4_reg     <= rho3_reg;
        c4_reg       <= uc;
        f4_reg.err   <= degen || (diff >= 34'(earth_radius_reg));
        f4_reg.clamp <= (35'(uc) + 35'(rho3_reg)) <= 35'(earth_radius_reg);
        f4_reg.neg   <= 1'b0;
        rho2_reg     <= 68'(rho3_reg) * 68'(rho3_reg);
        c2_reg       <= 68'(uc) * 68'(uc);
        re2_reg      <= 64'(earth_radius_reg) * 64'(earth_radius_reg);
    end

    // stage 5: numerator and denominator
    logic               v5_reg;
    logic signed [41:0] bh5_reg, bv5_reg;
    geo_flags_t         f5_reg;
    logic [DivW-1:0]    num5_reg, den5_reg;
    logic [DivW-1:0]    p_sum;

    assign p_sum = DivW'(rho2_reg) + DivW'(c2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v5_reg <= 1'b0;
        else        v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        bh5_reg      <= bh4_reg;
        bv5_reg      <= bv4_reg;
        f5_reg.err   <= f4_reg.err;
        f5_reg.clamp <= f4_reg.clamp;
        f5_reg.neg   <= p_sum < DivW'(re2_reg);
        num5_reg     <= (p_sum < DivW'(re2_reg)) ? DivW'(re2_reg) - p_sum
                                                 : p_sum - DivW'(re2_reg);
        den5_reg     <= DivW'({rho4_reg, 1'b0}) * DivW'(c4_reg);
    end

    // ---------------- divider chain: one quotient bit per stage
    // Valid cases have |N| < D, so 24 steps suffice; a 25th leading step is
    // always zero and keeps the stage count uniform.
    logic            dv_reg [QBits+1];
    logic [DivW-1:0] drem_reg [QBits+1];
    logic [DivW-1:0] dden_reg [QBits+1];
    logic [QBits-1:0] dq_reg [QBits+1];
    logic signed [41:0] dbh_reg [QBits+1];
    logic signed [41:0] dbv_reg [QBits+1];
    geo_flags_t      df_reg [QBits+1];

    always_comb
    begin
        dv_reg[0]   = v5_reg;
        drem_reg[0] = num5_reg;
        dden_reg[0] = den5_reg;
        dq_reg[0]   = '0;
        dbh_reg[0]  = bh5_reg;
        dbv_reg[0]  = bv5_reg;
        df_reg[0]   = f5_reg;
    end

    for (genvar i = 0; i < QBits; i++)
    begin : g_div
        logic [DivW-1:0]  rem_n;
        logic [QBits-1:0] q_n;

        pbp_div_stage u_stage (
            .rem_in  ((i == 0) ? '0 : drem_reg[i]),
            .div_in  (dden_reg[i]),
            .q_in    (dq_reg[i]),
            .rem_out (rem_n),
            .q_out   (q_n)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) dv_reg[i+1] <= 1'b0;
            else        dv_reg[i+1] <= dv_reg[i];
        end
        always_ff @(posedge clk)
        begin
            // first stage only loads the dividend, giving a zero bit
            drem_reg[i+1] <= (i == 0) ? drem_reg[i] : rem_n;
            dq_reg[i+1]   <= (i == 0) ? '0 : q_n;
            dden_reg[i+1] <= dden_reg[i];
            dbh_reg[i+1]  <= dbh_reg[i];
            dbv_reg[i+1]  <= dbv_reg[i];
            df_reg[i+1]   <= df_reg[i];
        end
    end

    // q with clamp applied
    logic [QBits-1:0] q_div;
    assign q_div = df_reg[QBits].clamp ? QBits'(1 << 24) : dq_reg[QBits];

    // stage: radicand 2^48 - q^2
    logic               sv0_reg;
    logic [48:0]        srad_reg;
    logic [QBits-1:0]   sq0_reg;
    logic signed [41:0] sbh0_reg, sbv0_reg;
    logic               serr0_reg, sneg0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) sv0_reg <= 1'b0;
        else        sv0_reg <= dv_reg[QBits];
    end
    always_ff @(posedge clk)
    begin
        srad_reg  <= (49'(1) << 48) - 49'(50'(q_div) * 50'(q_div));
        sq0_reg   <= q_div;
        sbh0_reg  <= dbh_reg[QBits];
        sbv0_reg  <= dbv_reg[QBits];
        serr0_reg <= df_reg[QBits].err;
        sneg0_reg <= df_reg[QBits].clamp | df_reg[QBits].neg;
    end

    // ---------------- square root chain: one root bit per stage
    logic               rv_reg  [SBits+1];
    logic [50:0]        rrem_reg [SBits+1];
    logic [48:0]        rx_reg  [SBits+1];
    logic [SBits-1:0]   rroot_reg [SBits+1];
    logic [QBits-1:0]   rq_reg  [SBits+1];
    logic signed [41:0] rbh_reg [SBits+1];
    logic signed [41:0] rbv_reg [SBits+1];
    logic               rerr_reg [SBits+1];
    logic               rneg_reg [SBits+1];

    always_comb
    begin
        rv_reg[0]    = sv0_reg;
        rrem_reg[0]  = '0;
        rx_reg[0]    = srad_reg;
        rroot_reg[0] = '0;
        rq_reg[0]    = sq0_reg;
        rbh_reg[0]   = sbh0_reg;
        rbv_reg[0]   = sbv0_reg;
        rerr_reg[0]  = serr0_reg;
        rneg_reg[0]  = sneg0_reg;
    end

    for (genvar j = 0; j < SBits; j++)
    begin : g_root
        logic [50:0] trem, trial;
        logic [49:0] xw;
        logic        ok;

        // bring down two radicand bits (radicand padded to 25 pairs),
        // try root*4+1
        always_comb
        begin
            xw    = {1'b0, rx_reg[j]};
            trem  = {rrem_reg[j][48:0], xw[49-2*j -: 2]};
            trial = 51'({rroot_reg[j], 2'b01});
            ok    = trem >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) rv_reg[j+1] <= 1'b0;
            else        rv_reg[j+1] <= rv_reg[j];
        end
        always_ff @(posedge clk)
        begin
            rrem_reg[j+1]  <= ok ? trem - trial : trem;
            rroot_reg[j+1] <= {rroot_reg[j][SBits-2:0], ok};
            rx_reg[j+1]    <= rx_reg[j];
            rq_reg[j+1]    <= rq_reg[j];
            rbh_reg[j+1]   <= rbh_reg[j];
            rbv_reg[j+1]   <= rbv_reg[j];
            rerr_reg[j+1]  <= rerr_reg[j];
            rneg_reg[j+1]  <= rneg_reg[j];
        end
    end

    // ---------------- back end: products, sum, shift, saturate
    logic               bev1_reg, bev2_reg, bev3_reg, bev4_reg;
    logic signed [67:0] ph_reg, pv_reg;
    logic signed [68:0] sum_reg;
    logic signed [44:0] shr_reg;
    logic               be1_reg, be2_reg, be3_reg;
    logic signed [25:0] eta_s;

    assign eta_s = rneg_reg[SBits] ? -$signed({1'b0, rq_reg[SBits]})
                                   : $signed({1'b0, rq_reg[SBits]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bev1_reg <= 1'b0;
            bev2_reg <= 1'b0;
            bev3_reg <= 1'b0;
            bev4_reg <= 1'b0;
        end
        else
        begin
            bev1_reg <= rv_reg[SBits];
            bev2_reg <= bev1_reg;
            bev3_reg <= bev2_reg;
            bev4_reg <= bev3_reg;
        end
    end

    // eta is 25 bits plus sign; the 42x26 products are split by synthesis
    always_ff @(posedge clk)
    begin
        ph_reg  <= 68'(rbh_reg[SBits]) * 68'(eta_s);
        pv_reg  <= 68'(rbv_reg[SBits]) * 68'($signed({1'b0, rroot_reg[SBits]}));
        be1_reg <= rerr_reg[SBits];
        sum_reg <= 69'(ph_reg) + 69'(pv_reg);
        be2_reg <= be1_reg;
        shr_reg <= 45'(sum_reg >>> 24);
        be3_reg <= be2_reg;
    end

    logic signed [31:0] bperp_reg;
    logic               gerr_reg;

    always_ff @(posedge clk)
    begin
        gerr_reg <= be3_reg;
        priority if (be3_reg)
            bperp_reg <= '0;
        else if (shr_reg > 45'sd2147483647)
            bperp_reg <= 32'sh7FFF_FFFF;
        else if (shr_reg < -45'sd2147483648)
            bperp_reg <= 32'sh8000_0000;
        else
            bperp_reg <= shr_reg[31:0];
    end

    assign done           = bev4_reg;
    assign bperp          = bperp_reg;
    assign geometry_error = gerr_reg;

endmodule

FILE: sv/pbp_checker.sv
// ----------------------------------------------------------------------------
// pbp_checker: port-level checks of the perpendicular baseline pixel
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module pbp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] bperp,
    input logic               geometry_error,
    input logic               cfg_ready
);

    // a flagged pixel always reads zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && geometry_error |-> bperp == '0)
        else $error("geometry error with nonzero bperp");

    // the block never refuses a pixel beat
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // config port always ready
    a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg_ready low");

    // no result strobe right after reset without an earlier start
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !done)
        else $error("result strobe straight out of reset");

    // every pixel beat comes back as a result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##60 done)
        else $error("result strobe missing after a pixel beat");

endmodule

bind perpendicular_baseline_pixel pbp_checker u_pbp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .bperp          (bperp),
    .geometry_error (geometry_error),
    .cfg_ready      (cfg_ready)
);
